### src/kce_pkg.sv
// shared constants and types for the keyframe curve evaluator
package kce_pkg;

   localparam int MAX_KEYS   = 64;
   localparam int KEY_IDX_W  = 6;
   localparam int KEY_CNT_W  = 7;
   localparam int FIX_W      = 32;
   localparam int OUT_W      = 40;
   localparam int FRAC_T     = 30;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_EVAL  = 1'b1;

   localparam logic [7:0] CURVE_HOLD  = 8'd1;
   localparam logic [7:0] CURVE_CUBIC = 8'd2;

   localparam logic CSR_CURVE_TYPE = 1'b0;
   localparam logic CSR_NUM_KEYS   = 1'b1;

   typedef struct packed {
      logic signed [FIX_W-1:0] frame;
      logic signed [FIX_W-1:0] value;
      logic signed [FIX_W-1:0] slope;
   } key_entry_type;

endpackage

### src/keyframe_curve_evaluator_core.sv
// Keyframe curve evaluator: keys are held in one 64-entry synchronous RAM of
// (frame, value, slope). An evaluate item with an unknown curve type or no
// keys is answered straight from the idle state. Step mode walks the RAM one
// key per cycle. Hermite mode reads the first and last keys, walks to the
// bracketing pair (one key per cycle), runs a restoring divider for t and
// then eight passes through one shared multiplier and a saturation step.
// Items are taken one at a time; the result register frees the input side as
// soon as its item is taken.
module keyframe_curve_evaluator_core
   import kce_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [KEY_IDX_W-1:0]        req_key_index,
   input  logic signed [FIX_W-1:0]     req_key_frame,
   input  logic signed [FIX_W-1:0]     req_key_value,
   input  logic signed [FIX_W-1:0]     req_key_slope,
   input  logic signed [FIX_W-1:0]     req_query_frame,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_defined,
   output logic signed [OUT_W-1:0]     rsp_curve_value,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [7:0]                  csr_data
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_STEP   = 4'd1;
   localparam logic [3:0] ST_HFIRST = 4'd2;
   localparam logic [3:0] ST_HLAST  = 4'd3;
   localparam logic [3:0] ST_HSCAN  = 4'd4;
   localparam logic [3:0] ST_DIV    = 4'd5;
   localparam logic [3:0] ST_M1     = 4'd6;
   localparam logic [3:0] ST_M2     = 4'd7;
   localparam logic [3:0] ST_M3     = 4'd8;
   localparam logic [3:0] ST_M4     = 4'd9;
   localparam logic [3:0] ST_M5     = 4'd10;
   localparam logic [3:0] ST_M6     = 4'd11;
   localparam logic [3:0] ST_M7     = 4'd12;
   localparam logic [3:0] ST_M8     = 4'd13;
   localparam logic [3:0] ST_SAT    = 4'd14;

   localparam int SUM_W = 52;
   localparam int MUL_W = 34;
   localparam logic signed [SUM_W-1:0] CV_MAX = SUM_W'(64'sd549755813887);
   localparam logic signed [SUM_W-1:0] CV_MIN = -SUM_W'(64'sd549755813888);

   key_entry_type key_mem [MAX_KEYS];
   key_entry_type rd_ff;
   logic [KEY_IDX_W-1:0] rd_addr;

   logic [3:0]              state_ff;
   logic [7:0]              curve_type_ff;
   logic [KEY_CNT_W-1:0]    num_keys_ff;
   logic [KEY_CNT_W-1:0]    n_ff;
   logic [KEY_IDX_W-1:0]    i_ff;
   logic signed [FIX_W-1:0] q_ff;
   logic [15:0]             step_v_ff;
   logic signed [FIX_W-1:0] l_frame_ff, l_value_ff, l_slope_ff;
   logic signed [FIX_W-1:0] r_value_ff, r_slope_ff;
   logic [32:0]             d_ff;
   logic [32:0]             rem_ff;
   logic [FRAC_T-1:0]       t_ff, t2_ff, t3_ff;
   logic [4:0]              cnt_ff;
   logic signed [MUL_W-1:0] hd_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_has_ff;
   logic signed [OUT_W-1:0] rsp_value_ff;

   logic                    req_acc;
   logic [KEY_CNT_W-1:0]    n_clamp;
   logic [KEY_CNT_W-1:0]    i_next;
   logic [15:0]             step_v_in;
   logic [33:0]             rem2;
   logic                    div_bit;
   logic signed [MUL_W-1:0] h00, h10, h01, h11;
   logic signed [MUL_W-1:0] op_a, op_b;
   logic signed [2*MUL_W-1:0] prod, prod30, prod16;
   logic signed [FIX_W:0]   q_minus_fl, fr_minus_fl;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign csr_ready = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_defined     = rsp_has_ff;
   assign rsp_curve_value = rsp_value_ff;

   assign n_clamp = (num_keys_ff > KEY_CNT_W'(MAX_KEYS)) ? KEY_CNT_W'(MAX_KEYS) : num_keys_ff;
   assign i_next  = {1'b0, i_ff} + KEY_CNT_W'(1);
   assign step_v_in = ((i_ff == '0) || (q_ff >= rd_ff.frame)) ? rd_ff.value[15:0] : step_v_ff;

   assign q_minus_fl  = {q_ff[FIX_W-1], q_ff} - {l_frame_ff[FIX_W-1], l_frame_ff};
   assign fr_minus_fl = {rd_ff.frame[FIX_W-1], rd_ff.frame}
                      - {l_frame_ff[FIX_W-1], l_frame_ff};

   assign rem2    = {rem_ff, 1'b0};
   assign div_bit = rem2 >= {1'b0, d_ff};

   assign h00 = 2 * $signed({4'd0, t3_ff}) - 3 * $signed({4'd0, t2_ff})
              + $signed(MUL_W'(1) << FRAC_T);
   assign h10 = $signed({4'd0, t3_ff}) - 2 * $signed({4'd0, t2_ff}) + $signed({4'd0, t_ff});
   assign h01 = 3 * $signed({4'd0, t2_ff}) - 2 * $signed({4'd0, t3_ff});
   assign h11 = $signed({4'd0, t3_ff}) - $signed({4'd0, t2_ff});

   always_comb begin
      unique case (state_ff)
         ST_M1: begin
            op_a = $signed({4'd0, t_ff});  op_b = $signed({4'd0, t_ff});
         end
         ST_M2: begin
            op_a = $signed({4'd0, t2_ff}); op_b = $signed({4'd0, t_ff});
         end
         ST_M3: begin
            op_a = h00; op_b = MUL_W'(l_value_ff);
         end
         ST_M4: begin
            op_a = h01; op_b = MUL_W'(r_value_ff);
         end
         ST_M5: begin
            op_a = h10; op_b = $signed({1'b0, d_ff});
         end
         ST_M6: begin
            op_a = hd_ff; op_b = MUL_W'(l_slope_ff);
         end
         ST_M7: begin
            op_a = h11; op_b = $signed({1'b0, d_ff});
         end
         ST_M8: begin
            op_a = hd_ff; op_b = MUL_W'(r_slope_ff);
         end
         default: begin
            op_a = '0; op_b = '0;
         end
      endcase
   end

   assign prod   = op_a * op_b;
   assign prod30 = prod >>> FRAC_T;
   assign prod16 = prod >>> 16;

   always_comb begin
      unique case (state_ff)
         ST_STEP:   rd_addr = i_next[KEY_IDX_W-1:0];
         ST_HFIRST: rd_addr = KEY_IDX_W'(n_ff - KEY_CNT_W'(1));
         ST_HSCAN:  rd_addr = i_next[KEY_IDX_W-1:0];
         default:   rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_action == ACT_WRITE) begin
         key_mem[req_key_index] <= '{frame: req_key_frame, value: req_key_value,
                                     slope: req_key_slope};
      end
      rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_type_ff <= '0;
         num_keys_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CURVE_TYPE: curve_type_ff <= csr_data;
            CSR_NUM_KEYS:   num_keys_ff   <= csr_data[KEY_CNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_action == ACT_EVAL) begin
                  q_ff <= req_query_frame;
                  n_ff <= n_clamp;
                  i_ff <= '0;
                  if (curve_type_ff != CURVE_HOLD && curve_type_ff != CURVE_CUBIC) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_has_ff   <= 1'b0;
                     rsp_value_ff <= '0;
                  end else if (n_clamp == '0) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_has_ff   <= 1'b1;
                     rsp_value_ff <= '0;
                  end else if (curve_type_ff == CURVE_HOLD) begin
                     state_ff <= ST_STEP;
                  end else begin
                     state_ff <= ST_HFIRST;
                  end
               end
            end
            ST_STEP: begin
               step_v_ff <= step_v_in;
               i_ff      <= i_next[KEY_IDX_W-1:0];
               if (q_ff < rd_ff.frame || i_next == n_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_has_ff   <= 1'b1;
                  rsp_value_ff <= {8'd0, step_v_in, 16'd0};
                  state_ff     <= ST_IDLE;
               end
            end
            ST_HFIRST: begin
               if (n_ff == KEY_CNT_W'(1) || q_ff <= rd_ff.frame) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_has_ff   <= 1'b1;
                  rsp_value_ff <= OUT_W'(rd_ff.value);
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_HLAST;
               end
            end
            ST_HLAST: begin
               if (q_ff >= rd_ff.frame) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_has_ff   <= 1'b1;
                  rsp_value_ff <= OUT_W'(rd_ff.value);
                  state_ff     <= ST_IDLE;
               end else begin
                  i_ff     <= '0;
                  state_ff <= ST_HSCAN;
               end
            end
            ST_HSCAN: begin
               if (rd_ff.frame <= q_ff) begin
                  l_frame_ff <= rd_ff.frame;
                  l_value_ff <= rd_ff.value;
                  l_slope_ff <= rd_ff.slope;
                  i_ff       <= i_next[KEY_IDX_W-1:0];
               end else begin
                  r_value_ff <= rd_ff.value;
                  r_slope_ff <= rd_ff.slope;
                  d_ff       <= fr_minus_fl;
                  rem_ff     <= q_minus_fl;
                  t_ff       <= '0;
                  cnt_ff     <= '0;
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= div_bit ? 33'(rem2 - {1'b0, d_ff}) : rem2[32:0];
               t_ff   <= {t_ff[FRAC_T-2:0], div_bit};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(FRAC_T - 1)) begin
                  state_ff <= ST_M1;
               end
            end
            ST_M1: begin
               t2_ff    <= prod[2*FRAC_T-1:FRAC_T];
               state_ff <= ST_M2;
            end
            ST_M2: begin
               t3_ff    <= prod[2*FRAC_T-1:FRAC_T];
               state_ff <= ST_M3;
            end
            ST_M3: begin
               sum_ff   <= prod30[SUM_W-1:0];
               state_ff <= ST_M4;
            end
            ST_M4: begin
               sum_ff   <= sum_ff + prod30[SUM_W-1:0];
               state_ff <= ST_M5;
            end
            ST_M5: begin
               hd_ff    <= prod30[MUL_W-1:0];
               state_ff <= ST_M6;
            end
            ST_M6: begin
               sum_ff   <= sum_ff + prod16[SUM_W-1:0];
               state_ff <= ST_M7;
            end
            ST_M7: begin
               hd_ff    <= prod30[MUL_W-1:0];
               state_ff <= ST_M8;
            end
            ST_M8: begin
               sum_ff   <= sum_ff + prod16[SUM_W-1:0];
               state_ff <= ST_SAT;
            end
            ST_SAT: begin
               rsp_valid_ff <= 1'b1;
               rsp_has_ff   <= 1'b1;
               priority if (sum_ff > CV_MAX) begin
                  rsp_value_ff <= CV_MAX[OUT_W-1:0];
               end else if (sum_ff < CV_MIN) begin
                  rsp_value_ff <= CV_MIN[OUT_W-1:0];
               end else begin
                  rsp_value_ff <= sum_ff[OUT_W-1:0];
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### src/kce_checker.sv
// port-level checks for the keyframe curve evaluator, bound to the top level
module kce_checker
   import kce_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_action,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_defined,
   input logic signed [OUT_W-1:0] rsp_curve_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_curve_value)
                                 && $stable(rsp_defined))
      else $error("stalled result item changed");

   a_no_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_defined |-> rsp_curve_value == '0)
      else $error("result without value carries nonzero data");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_WRITE |=> !$rose(rsp_valid))
      else $error("write item produced a result");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind keyframe_curve_evaluator_core kce_checker u_kce_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_action      (req_action),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_defined     (rsp_defined),
   .rsp_curve_value (rsp_curve_value)
);

### verif/tb.sv
// testbench for keyframe_curve_evaluator_core: directed rows then random phases
`timescale 1ns / 1ps

module tb;
   import kce_pkg::*;

   localparam longint CV_MAX = 64'sd549755813887;
   localparam longint CV_MIN = -64'sd549755813888;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic action;
      logic [KEY_IDX_W-1:0] idx;
      logic signed [FIX_W-1:0] frame, value, slope, query;
      logic csr_idx;
      logic [7:0] csr_val;
      bit typed;
      bit has;
      logic signed [OUT_W-1:0] cv;
   } dir_row_type;

   typedef struct {
      bit has;
      logic signed [OUT_W-1:0] cv;
   } curve_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = ACT_WRITE;
   logic [KEY_IDX_W-1:0] req_key_index = '0;
   logic signed [FIX_W-1:0] req_key_frame = '0;
   logic signed [FIX_W-1:0] req_key_value = '0;
   logic signed [FIX_W-1:0] req_key_slope = '0;
   logic signed [FIX_W-1:0] req_query_frame = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_defined;
   logic signed [OUT_W-1:0] rsp_curve_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = CSR_CURVE_TYPE;
   logic [7:0] csr_data = '0;

   logic signed [FIX_W-1:0] key_frame_mem [MAX_KEYS];
   logic signed [FIX_W-1:0] key_value_mem [MAX_KEYS];
   logic signed [FIX_W-1:0] key_slope_mem [MAX_KEYS];
   logic [7:0] curve_type_reg = '0;
   logic [KEY_CNT_W-1:0] num_keys_reg = '0;

   curve_result_type pending_values[$];
   dir_row_type dir_rows[$];
   int errors = 0;
   longint cycles = 0;
   int idle_mode = 0;
   logic hold_go = 1'b0;
   logic hold_on = 1'b0;

   keyframe_curve_evaluator_core dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // long receiver hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go <= 1'b0;
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= hold_on || ((idle_mode == 2) && ($urandom_range(0, 99) < 63))
         || ((idle_mode == 3) && ($urandom_range(0, 99) < 29));
   end

   always @(posedge clock) begin
      curve_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_values.size() == 0) begin
            $error("unexpected result item defined=%0d curve_value=%0d",
                   rsp_defined, rsp_curve_value);
            errors++;
         end else begin
            exp_r = pending_values.pop_front();
            if (rsp_defined !== exp_r.has) begin
               $error("defined expected %0d actual %0d", exp_r.has, rsp_defined);
               errors++;
            end
            if (rsp_curve_value !== exp_r.cv) begin
               $error("curve_value expected %0d actual %0d", exp_r.cv, rsp_curve_value);
               errors++;
            end
         end
      end
   end

   function automatic curve_result_type eval_curve(logic signed [FIX_W-1:0] q);
      curve_result_type res;
      longint qq, fl, d, t, t2, t3, h00, h10, h01, h11, sum;
      logic signed [FIX_W-1:0] v;
      int n, r, l;
      n = (num_keys_reg > MAX_KEYS) ? MAX_KEYS : num_keys_reg;
      qq = q;
      sum = 0;
      res.has = (curve_type_reg == CURVE_HOLD) || (curve_type_reg == CURVE_CUBIC);
      if (curve_type_reg == CURVE_HOLD && n > 0) begin
         v = key_value_mem[0];
         for (int i = 0; i < n; i++) begin
            if (qq < key_frame_mem[i])
               break;
            v = key_value_mem[i];
         end
         sum = longint'(v[15:0]) << 16;
      end else if (curve_type_reg == CURVE_CUBIC && n > 0) begin
         if (n == 1 || qq <= key_frame_mem[0])
            sum = key_value_mem[0];
         else if (qq >= key_frame_mem[n-1])
            sum = key_value_mem[n-1];
         else begin
            r = 0;
            while (r < n && key_frame_mem[r] <= qq)
               r++;
            if (r == 0 || r >= n)
               sum = key_value_mem[0];
            else begin
               l = r - 1;
               fl = key_frame_mem[l];
               d = longint'(key_frame_mem[r]) - fl;
               if (d <= 0)
                  sum = key_value_mem[r];
               else begin
                  t = ((qq - fl) <<< FRAC_T) / d;
                  t2 = (t * t) >>> FRAC_T;
                  t3 = (t2 * t) >>> FRAC_T;
                  h00 = 2 * t3 - 3 * t2 + (64'sd1 <<< FRAC_T);
                  h10 = t3 - 2 * t2 + t;
                  h01 = 3 * t2 - 2 * t3;
                  h11 = t3 - t2;
                  sum = (h00 * key_value_mem[l]) >>> FRAC_T;
                  sum += (h01 * key_value_mem[r]) >>> FRAC_T;
                  sum += (((h10 * d) >>> FRAC_T) * key_slope_mem[l]) >>> 16;
                  sum += (((h11 * d) >>> FRAC_T) * key_slope_mem[r]) >>> 16;
                  if (sum > CV_MAX)
                     sum = CV_MAX;
                  if (sum < CV_MIN)
                     sum = CV_MIN;
               end
            end
         end
      end
      res.cv = sum[OUT_W-1:0];
      return res;
   endfunction

   task automatic send_item(logic action, logic [KEY_IDX_W-1:0] idx,
                            logic signed [FIX_W-1:0] frame, logic signed [FIX_W-1:0] value,
                            logic signed [FIX_W-1:0] slope, logic signed [FIX_W-1:0] query,
                            bit typed, bit has, logic signed [OUT_W-1:0] cv);
      curve_result_type r;
      if (((idle_mode == 1) && ($urandom_range(0, 99) < 63))
          || ((idle_mode == 3) && ($urandom_range(0, 99) < 29))) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_key_index <= idx;
      req_key_frame <= frame;
      req_key_value <= value;
      req_key_slope <= slope;
      req_query_frame <= query;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (action == ACT_WRITE) begin
         key_frame_mem[idx] = frame;
         key_value_mem[idx] = value;
         key_slope_mem[idx] = slope;
      end else begin
         r = eval_curve(query);
         if (typed) begin
            r.has = has;
            r.cv = cv;
         end
         pending_values.insert(pending_values.size(), r);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_values.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_CURVE_TYPE)
         curve_type_reg = val;
      else
         num_keys_reg = val[KEY_CNT_W-1:0];
      @(posedge clock);
   endtask

   task automatic add_item(logic action, logic [KEY_IDX_W-1:0] idx,
                           logic signed [FIX_W-1:0] frame, logic signed [FIX_W-1:0] value,
                           logic signed [FIX_W-1:0] slope, logic signed [FIX_W-1:0] query,
                           bit typed, bit has, logic signed [OUT_W-1:0] cv);
      dir_row_type row;
      row.kind = ROW_ITEM;
      row.action = action;
      row.idx = idx;
      row.frame = frame;
      row.value = value;
      row.slope = slope;
      row.query = query;
      row.csr_idx = CSR_CURVE_TYPE;
      row.csr_val = '0;
      row.typed = typed;
      row.has = has;
      row.cv = cv;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   task automatic add_csr(logic idx, logic [7:0] val);
      dir_row_type row;
      row.kind = ROW_CSR;
      row.action = ACT_WRITE;
      row.idx = '0;
      row.frame = '0;
      row.value = '0;
      row.slope = '0;
      row.query = '0;
      row.csr_idx = idx;
      row.csr_val = val;
      row.typed = 1'b0;
      row.has = 1'b0;
      row.cv = '0;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   // sorted table with random content, one write item per entry
   task automatic fill_table(longint step_max);
      longint f;
      f = -64'sd2147483648 + $urandom_range(0, 1 << 20);
      for (int i = 0; i < MAX_KEYS; i++) begin
         if (f > 64'sd2147483647)
            f = 64'sd2147483647;
         send_item(ACT_WRITE, KEY_IDX_W'(i), f[31:0], $urandom() >>> $urandom_range(0, 24),
                   $urandom() >>> $urandom_range(0, 28), $urandom(), 0, 0, '0);
         if ($urandom_range(0, 15) != 0)
            f += $urandom_range(1, step_max);
      end
   endtask

   function automatic logic signed [FIX_W-1:0] pick_query();
      int k;
      longint a, b;
      k = $urandom_range(0, MAX_KEYS - 2);
      a = key_frame_mem[k];
      b = key_frame_mem[k+1];
      case ($urandom_range(0, 5))
         0: return $urandom();
         1, 2: return key_frame_mem[k] + $signed($urandom_range(0, 6)) - 3;
         default: begin
            if (b > a)
               return FIX_W'(a + ($urandom() % (b - a)));
            return key_frame_mem[k];
         end
      endcase
   endfunction

   initial begin
      logic [7:0] phase_type [8];
      logic [7:0] phase_count [8];
      longint step_max;
      dir_row_type row;
      phase_type = '{CURVE_HOLD, CURVE_CUBIC, CURVE_CUBIC, 8'd0,
                     CURVE_CUBIC, CURVE_HOLD, 8'd255, CURVE_CUBIC};
      phase_count = '{8'd64, 8'd2, 8'd64, 8'd64, 8'd0, 8'd1, 8'd30, 8'd64};

      add_item(ACT_EVAL, 0, 0, 0, 0, 32'sh80000000, 1, 0, '0);
      add_item(ACT_WRITE, 0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, '0);
      add_item(ACT_WRITE, 1, 0, 32'sh80000000, 32'sh80000000, 0, 0, 0, '0);
      add_item(ACT_WRITE, 2, 32'sh00010000, 32'shFFFFFFFF, 0, 0, 0, 0, '0);
      add_item(ACT_WRITE, 3, 32'sh7FFFFFFF, 32'sh0001ABCD, 32'sh00010000, 0, 0, 0, '0);
      add_item(ACT_WRITE, 63, 32'sh7FFFFFFF, 0, 32'shFFFFFFFF, 0, 0, 0, '0);
      add_item(ACT_EVAL, 0, 0, 0, 0, 32'sh7FFFFFFF, 1, 0, '0);
      add_csr(CSR_CURVE_TYPE, CURVE_HOLD);
      add_item(ACT_EVAL, 5, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 1, 1, '0);
      add_csr(CSR_NUM_KEYS, 8'd4);
      add_item(ACT_EVAL, 0, 0, 0, 0, 32'sh80000000, 0, 0, '0);
      add_item(ACT_EVAL, 0, 0, 0, 0, 0, 0, 0, '0);
      add_item(ACT_EVAL, 0, 0, 0, 0, 32'sh7FFFFFFF, 0, 0, '0);
      add_csr(CSR_CURVE_TYPE, CURVE_CUBIC);
      add_item(ACT_EVAL, 0, 0, 0, 0, 32'sh80000000, 1, 1, 40'sh007FFFFFFF);
      add_item(ACT_EVAL, 0, 0, 0, 0, 32'sh7FFFFFFF, 1, 1, 40'sh000001ABCD);
      add_item(ACT_EVAL, 0, 0, 0, 0, 32'sh00008000, 0, 0, '0);
      add_item(ACT_EVAL, 0, 0, 0, 0, 32'shC0000000, 0, 0, '0);
      add_csr(CSR_NUM_KEYS, 8'd1);
      add_item(ACT_EVAL, 0, 0, 0, 0, 32'sh00000005, 1, 1, 40'sh007FFFFFFF);
      add_csr(CSR_CURVE_TYPE, 8'd255);
      add_item(ACT_EVAL, 0, 0, 0, 0, 32'sh00000005, 1, 0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            drain();
            write_csr(row.csr_idx, row.csr_val);
         end else
            send_item(row.action, row.idx, row.frame, row.value, row.slope, row.query,
                      row.typed, row.has, row.cv);
      end

      for (int p = 0; p < 8; p++) begin
         drain();
         idle_mode = p % 4;
         write_csr(CSR_CURVE_TYPE, (p == 3) ? 8'($urandom_range(3, 254)) : phase_type[p]);
         write_csr(CSR_NUM_KEYS, (p == 6) ? 8'($urandom_range(3, 63)) : phase_count[p]);
         case (p % 3)
            0: step_max = 16;
            1: step_max = 1 << 18;
            default: step_max = 60000000;
         endcase
         fill_table(step_max);
         for (int k = 0; k < 180; k++) begin
            if (p == 1 && k == 40)
               hold_go <= 1'b1;
            if (p == 2 && k == 90)
               drain();
            if ($urandom_range(0, 9) == 0)
               send_item(ACT_WRITE, KEY_IDX_W'($urandom()), $urandom(), $urandom(),
                         $urandom(), $urandom(), 0, 0, '0);
            else
               send_item(ACT_EVAL, KEY_IDX_W'($urandom()), $urandom(), $urandom(),
                         $urandom(), pick_query(), 0, 0, '0);
         end
      end

      drain();
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
